// File: hw/rtl/asc_pkg.sv
// Shared constants and types for the allocation size-class mapper.
`default_nettype none

package asc_pkg;

   localparam int SIZE_W    = 20;
   localparam int ALIGNED_W = 19;
   localparam int INDEX_W   = 8;
   localparam int BLOCKS_W  = 10;
   localparam int PAGES_W   = 7;

   localparam int MAX_BLOCK_BYTES = 262144;
   localparam int PAGE_BITS       = 13;

   // Remainder holds values below the divisor, which reaches MAX_BLOCK_BYTES.
   localparam int REM_W = $clog2(MAX_BLOCK_BYTES) + 1;

   localparam int BLOCK_MAX_CLAMP = 512;
   localparam int BLOCK_MIN_CLAMP = 2;
   localparam int PAGE_FIELD_MAX  = 127;

   // Quotient bits needed below the upper clamp; one divider cell per bit.
   localparam int QUO_W     = $clog2(BLOCK_MAX_CLAMP);
   localparam int NUM_CELLS = QUO_W;

   // Partial remainder after the dividend bits above the quotient window.
   localparam logic [REM_W-1:0] REM_START = REM_W'(MAX_BLOCK_BYTES >> QUO_W);

   localparam int PROD_W = BLOCKS_W + REM_W;

   // Range limits and free-list bases.
   localparam int RANGE0_HI = 128;
   localparam int RANGE1_HI = 1024;
   localparam int RANGE2_HI = 8 * 1024;
   localparam int RANGE3_HI = 64 * 1024;

   localparam int BASE1 = 16;
   localparam int BASE2 = 72;
   localparam int BASE3 = 128;
   localparam int BASE4 = 184;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [REM_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
   } asc_cell_data_type;

endpackage

`default_nettype wire

// File: hw/rtl/asc_div_cell.sv
// One restoring-division cell: shifts the remainder, subtracts the size, emits a quotient bit.
`default_nettype none

module asc_div_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  asc_pkg::asc_cell_data_type  in_data,
   output logic                        out_valid,
   input  wire                         out_ready,
   output asc_pkg::asc_cell_data_type  out_data
);
   import asc_pkg::*;

   logic              valid_ff;
   asc_cell_data_type data_ff;
   asc_cell_data_type data_in;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  divisor;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      shifted      = {in_data.rem[REM_W-2:0], 1'b0};
      divisor      = in_data.size[REM_W-1:0];
      data_in.size = in_data.size;
      if (shifted >= divisor) begin
         data_in.rem = shifted - divisor;
         data_in.quo = {in_data.quo[QUO_W-2:0], 1'b1};
      end else begin
         data_in.rem = shifted;
         data_in.quo = {in_data.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/asc_out_stage.sv
// Output register: alignment, bucket index, block clamp and page count.
`default_nettype none

module asc_out_stage (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  asc_pkg::asc_cell_data_type          in_data,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output logic [asc_pkg::ALIGNED_W-1:0]       out_aligned_size,
   output logic [asc_pkg::INDEX_W-1:0]         out_class_index,
   output logic [asc_pkg::BLOCKS_W-1:0]        out_block_count,
   output logic [asc_pkg::PAGES_W-1:0]         out_page_count,
   output logic                                out_size_invalid
);
   import asc_pkg::*;

   logic                 valid_ff;
   logic [ALIGNED_W-1:0] aligned_ff, aligned_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [BLOCKS_W-1:0]  blocks_ff, blocks_in;
   logic [PAGES_W-1:0]   pages_ff, pages_in;
   logic                 invalid_ff, invalid_in;

   logic [SIZE_W-1:0]    size;
   logic [SIZE_W-1:0]    mask;
   logic [SIZE_W-1:0]    lo;
   logic [SIZE_W-1:0]    base;
   logic [SIZE_W-1:0]    rounded;
   logic [SIZE_W-1:0]    offset_up;
   logic [SIZE_W-1:0]    index_full;
   logic [3:0]           shift;
   logic [PROD_W-1:0]    product;
   logic [PROD_W-1:0]    page_full;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_aligned_size = aligned_ff;
   assign out_class_index  = index_ff;
   assign out_block_count  = blocks_ff;
   assign out_page_count   = pages_ff;
   assign out_size_invalid = invalid_ff;

   always_comb begin
      size = in_data.size;
      priority if (size <= SIZE_W'(RANGE0_HI)) begin
         shift = 4'd3;  lo = '0;                   base = '0;
      end else if (size <= SIZE_W'(RANGE1_HI)) begin
         shift = 4'd4;  lo = SIZE_W'(RANGE0_HI);   base = SIZE_W'(BASE1);
      end else if (size <= SIZE_W'(RANGE2_HI)) begin
         shift = 4'd7;  lo = SIZE_W'(RANGE1_HI);   base = SIZE_W'(BASE2);
      end else if (size <= SIZE_W'(RANGE3_HI)) begin
         shift = 4'd10; lo = SIZE_W'(RANGE2_HI);   base = SIZE_W'(BASE3);
      end else begin
         shift = 4'd13; lo = SIZE_W'(RANGE3_HI);   base = SIZE_W'(BASE4);
      end
      mask       = (SIZE_W'(1) << shift) - SIZE_W'(1);
      rounded    = (size + mask) & ~mask;
      offset_up  = (size - lo + mask) >> shift;
      index_full = offset_up - SIZE_W'(1) + base;

      // Quotient is exact only above the upper clamp's size; smaller sizes clamp high.
      if (size <= SIZE_W'(BLOCK_MAX_CLAMP)) begin
         blocks_in = BLOCKS_W'(BLOCK_MAX_CLAMP);
      end else if (in_data.quo < QUO_W'(BLOCK_MIN_CLAMP)) begin
         blocks_in = BLOCKS_W'(BLOCK_MIN_CLAMP);
      end else begin
         blocks_in = BLOCKS_W'(in_data.quo);
      end

      product   = PROD_W'(blocks_in) * PROD_W'(size[REM_W-1:0]);
      page_full = product >> PAGE_BITS;
      if (page_full == '0) begin
         pages_in = PAGES_W'(1);
      end else if (page_full > PROD_W'(PAGE_FIELD_MAX)) begin
         pages_in = PAGES_W'(PAGE_FIELD_MAX);
      end else begin
         pages_in = page_full[PAGES_W-1:0];
      end

      invalid_in = (size == '0) || (size > SIZE_W'(MAX_BLOCK_BYTES));
      aligned_in = rounded[ALIGNED_W-1:0];
      index_in   = index_full[INDEX_W-1:0];
      if (invalid_in) begin
         aligned_in = '0;
         index_in   = '0;
         blocks_in  = '0;
         pages_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         aligned_ff <= aligned_in;
         index_ff   <= index_in;
         blocks_ff  <= blocks_in;
         pages_ff   <= pages_in;
         invalid_ff <= invalid_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/alloc_size_class_mapper.sv
// Pipeline: the chain of divider cells, then the output register.
// Throughput: one transaction per cycle while rsp_ready is high; each divider cell and the output
// register stalls on its own, so bubbles collapse while the sink holds off.
// The batch count comes from a chain of restoring-division cells, one
// quotient bit per cell. Synchronous active-high reset clears all valid flags.
`default_nettype none

module alloc_size_class_mapper (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [asc_pkg::SIZE_W-1:0]      req_size,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [asc_pkg::ALIGNED_W-1:0]   rsp_aligned_size,
   output logic [asc_pkg::INDEX_W-1:0]     rsp_class_index,
   output logic [asc_pkg::BLOCKS_W-1:0]    rsp_block_count,
   output logic [asc_pkg::PAGES_W-1:0]     rsp_page_count,
   output logic                            rsp_size_invalid
);
   import asc_pkg::*;

   logic              link_valid [NUM_CELLS+1];
   logic              link_ready [NUM_CELLS+1];
   asc_cell_data_type link_data  [NUM_CELLS+1];

   assign link_valid[0]     = req_valid;
   assign req_ready         = link_ready[0];
   assign link_data[0].size = req_size;
   assign link_data[0].rem  = REM_START;
   assign link_data[0].quo  = '0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      asc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   asc_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (link_valid[NUM_CELLS]),
      .in_ready         (link_ready[NUM_CELLS]),
      .in_data          (link_data[NUM_CELLS]),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_aligned_size (rsp_aligned_size),
      .out_class_index  (rsp_class_index),
      .out_block_count  (rsp_block_count),
      .out_page_count   (rsp_page_count),
      .out_size_invalid (rsp_size_invalid)
   );

endmodule

`default_nettype wire

// File: hw/rtl/asc_port_monitor.sv
// Port-level assertions for the size-class mapper, bound to the top level.
`default_nettype none

module asc_port_monitor (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [asc_pkg::ALIGNED_W-1:0]   rsp_aligned_size,
   input wire [asc_pkg::INDEX_W-1:0]     rsp_class_index,
   input wire [asc_pkg::BLOCKS_W-1:0]    rsp_block_count,
   input wire [asc_pkg::PAGES_W-1:0]     rsp_page_count,
   input wire                            rsp_size_invalid
);
   import asc_pkg::*;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_invalid |->
         rsp_aligned_size == '0 && rsp_class_index == '0 &&
         rsp_block_count == '0 && rsp_page_count == '0)
      else $error("invalid transaction carries nonzero fields");

   a_counts_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_size_invalid |->
         rsp_block_count >= BLOCKS_W'(BLOCK_MIN_CLAMP) &&
         rsp_block_count <= BLOCKS_W'(BLOCK_MAX_CLAMP) &&
         rsp_page_count != '0)
      else $error("block or page count out of range");

   a_class_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_size_invalid |->
         rsp_aligned_size[2:0] == 3'b000 && rsp_aligned_size != '0 &&
         rsp_class_index <= INDEX_W'(207))
      else $error("aligned size or class index malformed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_aligned_size) && $stable(rsp_class_index) &&
         $stable(rsp_block_count) && $stable(rsp_page_count) &&
         $stable(rsp_size_invalid))
      else $error("stalled response changed");

endmodule

bind alloc_size_class_mapper asc_port_monitor u_port_monitor (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_aligned_size (rsp_aligned_size),
   .rsp_class_index  (rsp_class_index),
   .rsp_block_count  (rsp_block_count),
   .rsp_page_count   (rsp_page_count),
   .rsp_size_invalid (rsp_size_invalid)
);

`default_nettype wire
